>>> src/i2crm_pkg.sv
package i2crm_pkg;

    localparam int DEFAULT_MAX_READ_BYTES = 16;
    localparam int CFG_ADDR_W             = 4;
    localparam int CFG_DATA_W             = 32;

    localparam logic [9:0] START_GAP_TICKS = 10'd20;

    localparam logic [7:0] HALF_BIT_RESET   = 8'd3;
    localparam logic [7:0] SETTLE_RESET     = 8'd6;
    localparam logic [9:0] POST_WRITE_RESET = 10'd800;

    localparam logic [1:0] REG_HALF_BIT   = 2'd0;
    localparam logic [1:0] REG_SETTLE     = 2'd1;
    localparam logic [1:0] REG_POST_WRITE = 2'd2;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [4:0] read_count;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic       ack_error;
    } out_word_t;

    typedef struct packed {
        logic [7:0] half_bit_ticks;
        logic [7:0] settle_ticks;
        logic [9:0] post_write_ticks;
    } cfg_t;

endpackage

>>> src/i2crm_cfg.sv
module i2crm_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2crm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [i2crm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [i2crm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output i2crm_pkg::cfg_t                    cfg
);
    import i2crm_pkg::*;

    logic [7:0] half_bit_reg;
    logic [7:0] settle_reg;
    logic [9:0] post_write_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg   <= HALF_BIT_RESET;
            settle_reg     <= SETTLE_RESET;
            post_write_reg <= POST_WRITE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_HALF_BIT:   half_bit_reg   <= pwdata[7:0];
                REG_SETTLE:     settle_reg     <= pwdata[7:0];
                REG_POST_WRITE: post_write_reg <= pwdata[9:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_HALF_BIT:   prdata = {24'd0, half_bit_reg};
            REG_SETTLE:     prdata = {24'd0, settle_reg};
            REG_POST_WRITE: prdata = {22'd0, post_write_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.half_bit_ticks   = half_bit_reg;
    assign cfg.settle_ticks     = settle_reg;
    assign cfg.post_write_ticks = post_write_reg;

endmodule

>>> src/i2crm_seq.sv
module i2crm_seq #(
    parameter int MAX_READ_BYTES = i2crm_pkg::DEFAULT_MAX_READ_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  i2crm_pkg::in_word_t  word,
    input  i2crm_pkg::cfg_t      cfg,
    output i2crm_pkg::out_word_t result
);
    import i2crm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_REL, PH_START_SDA, PH_START_GAP, PH_TX_HIGH, PH_TX_LOW,
        PH_ACK_HIGH, PH_ACK_LOW, PH_RX_HIGH, PH_RX_LOW, PH_MACK_SET, PH_MACK_HIGH,
        PH_MACK_LOW, PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_REL, PH_POST
    } phase_t;

    typedef enum logic [1:0] {ST_ADDR, ST_REG, ST_RADDR, ST_DATA} stage_t;

    localparam logic [4:0] MAX_COUNT = 5'(MAX_READ_BYTES);

    phase_t     phase_reg, phase_next;
    stage_t     stage_reg, stage_next;
    logic [9:0] tick_reg, tick_next, tick_inc, len;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [4:0] bytes_left_reg, bytes_left_next, cnt;
    logic [6:0] held_device_reg, held_device_next;
    logic [7:0] held_register_reg, held_register_next;
    logic [7:0] held_data_reg, held_data_next;
    logic       is_read_reg, is_read_next;
    logic       nack_reg, nack_next;
    logic       scl_drv, sda_drv, rvalid, rlast, done;
    logic [7:0] rdata;
    logic [9:0] len_sel;

    always_comb
    begin
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        tick_next          = tick_reg;
        bit_index_next     = bit_index_reg;
        shift_next         = shift_reg;
        bytes_left_next    = bytes_left_reg;
        held_device_next   = held_device_reg;
        held_register_next = held_register_reg;
        held_data_next     = held_data_reg;
        is_read_next       = is_read_reg;
        nack_next          = nack_reg;
        scl_drv            = 1'b0;
        sda_drv            = 1'b0;
        rvalid             = 1'b0;
        rdata              = 8'd0;
        rlast              = 1'b0;
        done               = 1'b0;
        len_sel            = 10'd0;
        len                = 10'd1;
        tick_inc           = 10'd0;

        cnt = (word.read_count == 5'd0) ? 5'd1 : word.read_count;
        if (cnt > MAX_COUNT)
        begin
            cnt = MAX_COUNT;
        end

        if (phase_reg == PH_IDLE && (word.func == FUNC_WRITE || word.func == FUNC_READ))
        begin
            held_device_next   = word.device_addr;
            held_register_next = word.reg_addr;
            held_data_next     = word.write_data;
            bytes_left_next    = cnt;
            is_read_next       = (word.func == FUNC_READ);
            nack_next          = 1'b0;
            stage_next         = ST_ADDR;
            shift_next         = {word.device_addr, 1'b0};
            bit_index_next     = 4'd0;
            tick_next          = 10'd0;
            phase_next         = PH_START_REL;
        end

        if (phase_next != PH_IDLE)
        begin
            case (phase_next)
                PH_START_SDA:
                    sda_drv = 1'b1;
                PH_START_GAP, PH_STOP_LOW:
                begin
                    scl_drv = 1'b1;
                    sda_drv = 1'b1;
                end
                PH_TX_HIGH:
                    sda_drv = ~shift_next[7];
                PH_TX_LOW:
                begin
                    scl_drv = 1'b1;
                    sda_drv = ~shift_next[7];
                end
                PH_ACK_LOW, PH_RX_LOW:
                    scl_drv = 1'b1;
                PH_MACK_SET, PH_MACK_LOW:
                begin
                    scl_drv = 1'b1;
                    sda_drv = (bytes_left_next > 5'd1);
                end
                PH_MACK_HIGH:
                    sda_drv = (bytes_left_next > 5'd1);
                PH_STOP_HIGH:
                    sda_drv = 1'b1;
                default:
                    ;
            endcase

            case (phase_next)
                PH_TX_HIGH, PH_TX_LOW, PH_ACK_LOW, PH_RX_HIGH, PH_RX_LOW:
                    len_sel = {2'd0, cfg.half_bit_ticks};
                PH_START_GAP:
                    len_sel = START_GAP_TICKS;
                PH_POST:
                    len_sel = cfg.post_write_ticks;
                default:
                    len_sel = {2'd0, cfg.settle_ticks};
            endcase
            len     = (len_sel == 10'd0) ? 10'd1 : len_sel;

            tick_inc = tick_next + 10'd1;
            if (tick_inc >= len)
            begin
                tick_next = 10'd0;
                case (phase_next)
                    PH_START_REL:
                        phase_next = PH_START_SDA;
                    PH_START_SDA:
                    begin
                        bit_index_next = 4'd0;
                        phase_next = (stage_next == ST_ADDR && !is_read_next) ?
                                     PH_START_GAP : PH_TX_HIGH;
                    end
                    PH_START_GAP:
                        phase_next = PH_TX_HIGH;
                    PH_TX_HIGH:
                        phase_next = PH_TX_LOW;
                    PH_TX_LOW:
                    begin
                        shift_next     = {shift_next[6:0], 1'b0};
                        bit_index_next = bit_index_next + 4'd1;
                        phase_next = (bit_index_next >= 4'd8) ? PH_ACK_HIGH : PH_TX_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        if (word.sda_in)
                        begin
                            nack_next = 1'b1;
                        end
                        phase_next = PH_ACK_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        bit_index_next = 4'd0;
                        case (stage_next)
                            ST_ADDR:
                            begin
                                stage_next = ST_REG;
                                shift_next = held_register_next;
                                phase_next = PH_TX_HIGH;
                            end
                            ST_REG:
                            begin
                                if (is_read_next)
                                begin
                                    stage_next = ST_RADDR;
                                    shift_next = {held_device_next, 1'b1};
                                    phase_next = PH_START_REL;
                                end
                                else
                                begin
                                    stage_next = ST_DATA;
                                    shift_next = held_data_next;
                                    phase_next = PH_TX_HIGH;
                                end
                            end
                            ST_RADDR:
                            begin
                                shift_next = 8'd0;
                                phase_next = PH_RX_HIGH;
                            end
                            default:
                                phase_next = PH_STOP_LOW;
                        endcase
                    end
                    PH_RX_HIGH:
                    begin
                        shift_next     = {shift_next[6:0], word.sda_in};
                        bit_index_next = bit_index_next + 4'd1;
                        if (bit_index_next >= 4'd8)
                        begin
                            rvalid = 1'b1;
                            rdata  = shift_next;
                            rlast  = (bytes_left_next <= 5'd1);
                        end
                        phase_next = PH_RX_LOW;
                    end
                    PH_RX_LOW:
                        phase_next = (bit_index_next >= 4'd8) ? PH_MACK_SET : PH_RX_HIGH;
                    PH_MACK_SET:
                        phase_next = PH_MACK_HIGH;
                    PH_MACK_HIGH:
                        phase_next = PH_MACK_LOW;
                    PH_MACK_LOW:
                    begin
                        if (bytes_left_next != 5'd0)
                        begin
                            bytes_left_next = bytes_left_next - 5'd1;
                        end
                        if (bytes_left_next == 5'd0)
                        begin
                            phase_next = PH_STOP_LOW;
                        end
                        else
                        begin
                            bit_index_next = 4'd0;
                            shift_next     = 8'd0;
                            phase_next     = PH_RX_HIGH;
                        end
                    end
                    PH_STOP_LOW:
                        phase_next = PH_STOP_HIGH;
                    PH_STOP_HIGH:
                        phase_next = PH_STOP_REL;
                    PH_STOP_REL:
                    begin
                        if (!is_read_next && cfg.post_write_ticks != 10'd0)
                        begin
                            phase_next = PH_POST;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            stage_reg         <= ST_ADDR;
            tick_reg          <= '0;
            bit_index_reg     <= '0;
            shift_reg         <= '0;
            bytes_left_reg    <= '0;
            held_device_reg   <= '0;
            held_register_reg <= '0;
            held_data_reg     <= '0;
            is_read_reg       <= 1'b0;
            nack_reg          <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            tick_reg          <= tick_next;
            bit_index_reg     <= bit_index_next;
            shift_reg         <= shift_next;
            bytes_left_reg    <= bytes_left_next;
            held_device_reg   <= held_device_next;
            held_register_reg <= held_register_next;
            held_data_reg     <= held_data_next;
            is_read_reg       <= is_read_next;
            nack_reg          <= nack_next;
        end
    end

    assign result.scl_low    = scl_drv;
    assign result.sda_low    = sda_drv;
    assign result.busy_res   = (phase_next != PH_IDLE);
    assign result.read_valid = rvalid;
    assign result.read_data  = rdata;
    assign result.read_last  = rlast;
    assign result.done_res   = done;
    assign result.ack_error  = nack_next;

endmodule

>>> src/i2c_register_master.sv
// I2C register master, one bus timing tick per input word.
//
// Input channel (in_valid / in_stall / in_word): each accepted word is one
// tick. func selects tick only, start write, or start read; commands that
// arrive while a transaction is running act as plain ticks. sda_in is the
// sampled SDA level for that tick.
// Output channel (out_valid / out_stall / out_word): exactly one word per
// accepted input word, in order, carrying the SCL/SDA pull-down drive,
// busy/done status, received bytes and the sticky acknowledge error.
// Configuration: APB-style port, registers at 0x0 half-bit ticks,
// 0x4 settle ticks, 0x8 post-write ticks; pready is tied high.
// Each input word is captured in the input register, then its result word
// in the result register, which drives out_word. Throughput: one word per
// cycle while the output is not stalled; the sequencer state updates once
// per tick.
// Reset: sequencer idle, both lines released, registers at 3 / 6 / 800.
// When out_stall is held with out_valid set, the result register and the input register
// both hold, and in_stall rises once the input register is full.
module i2c_register_master #(
    parameter int MAX_READ_BYTES = i2crm_pkg::DEFAULT_MAX_READ_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  i2crm_pkg::in_word_t                in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output i2crm_pkg::out_word_t               out_word,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2crm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [i2crm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [i2crm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import i2crm_pkg::*;

    cfg_t      cfg;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t step_word;
    out_word_t out_word_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    i2crm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2crm_seq #(
        .MAX_READ_BYTES (MAX_READ_BYTES)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (in_word_reg),
        .cfg    (cfg),
        .result (step_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_word_reg <= in_word;
        end
        if (fire)
        begin
            out_word_reg <= step_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> src/i2crm_checker.sv
module i2crm_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input i2crm_pkg::out_word_t  out_word
);
    import i2crm_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.done_res |-> !out_word.busy_res)
        else $error("done with busy still set");

    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.read_valid |-> out_word.read_data == 8'd0)
        else $error("read data without read valid");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.read_last |-> out_word.read_valid && out_word.busy_res)
        else $error("read last outside a received byte");

endmodule

bind i2c_register_master i2crm_checker u_i2crm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
